// ----- src/ndtp_pkg.sv -----
// Shared types, constants and helpers for the numeric date-time parser.
`timescale 1ns / 1ps
`default_nettype none

package ndtp_pkg;

  localparam logic [6:0] DefCenturyReset = 7'd19;
  localparam logic [6:0] MaxCentury      = 7'd99;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [2:0] FldCentury = 3'd0;
  localparam logic [2:0] FldYear    = 3'd1;
  localparam logic [2:0] FldMonth   = 3'd2;
  localparam logic [2:0] FldDay     = 3'd3;
  localparam logic [2:0] FldHour    = 3'd4;
  localparam logic [2:0] FldMinute  = 3'd5;
  localparam logic [2:0] FldSecond  = 3'd6;

  typedef enum logic [9:0] {
    PH_BLANK   = 10'b00_0000_0001,
    PH_CENTURY = 10'b00_0000_0010,
    PH_YEAR    = 10'b00_0000_0100,
    PH_MONTH   = 10'b00_0000_1000,
    PH_DAY     = 10'b00_0001_0000,
    PH_HOUR    = 10'b00_0010_0000,
    PH_MINUTE  = 10'b00_0100_0000,
    PH_SECOND  = 10'b00_1000_0000,
    PH_DONE    = 10'b01_0000_0000,
    PH_BAD     = 10'b10_0000_0000
  } ndtp_phase_e;

  typedef struct packed {
    logic        valid_res;
    logic [2:0]  failed_field;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [1:0]  time_fields_given;
    logic        leap_year;
  } ndtp_res_t;

  // Field number of a field phase; 0 for the others.
  function automatic logic [2:0] fld_idx(ndtp_phase_e ph);
    logic [2:0] idx;
    case (ph)
      PH_CENTURY: idx = FldCentury;
      PH_YEAR:    idx = FldYear;
      PH_MONTH:   idx = FldMonth;
      PH_DAY:     idx = FldDay;
      PH_HOUR:    idx = FldHour;
      PH_MINUTE:  idx = FldMinute;
      PH_SECOND:  idx = FldSecond;
      default:    idx = FldCentury;
    endcase
    return idx;
  endfunction

  function automatic ndtp_phase_e next_phase(ndtp_phase_e ph);
    ndtp_phase_e nx;
    case (ph)
      PH_CENTURY: nx = PH_YEAR;
      PH_YEAR:    nx = PH_MONTH;
      PH_MONTH:   nx = PH_DAY;
      PH_DAY:     nx = PH_HOUR;
      PH_HOUR:    nx = PH_MINUTE;
      PH_MINUTE:  nx = PH_SECOND;
      default:    nx = PH_DONE;
    endcase
    return nx;
  endfunction

  // Days in month, February without leap adjustment; 0 for no month.
  function automatic logic [4:0] month_days(logic [3:0] m);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // Gregorian leap test on century*100 + yl, both below 100.
  function automatic logic is_leap(logic [6:0] cen, logic [6:0] yl);
    logic lp;
    if (yl != 7'd0) begin
      lp = (yl[1:0] == 2'b00);
    end else begin
      lp = (cen[1:0] == 2'b00);
    end
    return lp;
  endfunction

endpackage

`default_nettype wire

// ----- src/ndtp_core.sv -----
// Parser state and per-character next-state logic; builds the result on an end request.
`timescale 1ns / 1ps
`default_nettype none

module ndtp_core import ndtp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] ch_i,
  input  wire logic       is_end_i,
  input  wire logic [6:0] default_century_i,
  output ndtp_res_t       res_o
);

  ndtp_phase_e phase_q, phase_d;
  logic [3:0]  first_q, first_d;
  logic        has_dig_q, has_dig_d;
  logic        skip_q, skip_d;
  logic [6:0]  century_q, century_d;
  logic [6:0]  year_lo_q, year_lo_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;
  logic [1:0]  given_q, given_d;
  logic [2:0]  bad_fld_q, bad_fld_d;

  logic        is_dig;
  logic [6:0]  val;
  logic        do_field;
  ndtp_phase_e cur_ph;
  logic [4:0]  day_lim;
  logic        ok;
  logic        leap_now;

  assign is_dig = (ch_i >= ChZero) && (ch_i <= ChNine);
  assign val    = {first_q, 3'b000} + {2'b00, first_q, 1'b0} + {3'b000, ch_i[3:0]};
  assign leap_now = is_leap(century_q, year_lo_q);

  always_comb begin
    day_lim = month_days(month_q);
    if ((month_q == 4'd2) && leap_now) begin
      day_lim = 5'd29;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    first_d   = first_q;
    has_dig_d = has_dig_q;
    skip_d    = skip_q;
    century_d = century_q;
    year_lo_d = year_lo_q;
    month_d   = month_q;
    day_d     = day_q;
    hour_d    = hour_q;
    minute_d  = minute_q;
    second_d  = second_q;
    given_d   = given_q;
    bad_fld_d = bad_fld_q;
    do_field  = 1'b0;
    cur_ph    = phase_q;
    ok        = 1'b1;

    if (accept_i) begin
      if (is_end_i) begin
        phase_d   = PH_BLANK;
        first_d   = 4'd0;
        has_dig_d = 1'b0;
        skip_d    = 1'b0;
        century_d = 7'd0;
        year_lo_d = 7'd0;
        month_d   = 4'd0;
        day_d     = 5'd0;
        hour_d    = 5'd0;
        minute_d  = 6'd0;
        second_d  = 6'd0;
        given_d   = 2'd0;
        bad_fld_d = 3'd0;
      end else begin
        case (phase_q)
          PH_BLANK: begin
            if (ch_i == ChPlus) begin
              phase_d = PH_CENTURY;
            end else if (ch_i != ChSpace) begin
              century_d = (default_century_i > MaxCentury) ? MaxCentury : default_century_i;
              phase_d   = PH_YEAR;
              cur_ph    = PH_YEAR;
              do_field  = 1'b1;
            end
          end
          PH_CENTURY, PH_YEAR, PH_MONTH, PH_DAY,
          PH_HOUR, PH_MINUTE, PH_SECOND: begin
            do_field = 1'b1;
          end
          default: begin
            do_field = 1'b0;
          end
        endcase

        if (do_field) begin
          if (!has_dig_q) begin
            if (is_dig) begin
              first_d   = ch_i[3:0];
              has_dig_d = 1'b1;
            end else begin
              skip_d = 1'b1;
            end
          end else if (!is_dig) begin
            phase_d   = PH_BAD;
            bad_fld_d = fld_idx(cur_ph);
          end else begin
            case (cur_ph)
              PH_CENTURY: century_d = val;
              PH_YEAR:    year_lo_d = val;
              PH_MONTH: begin
                ok = (val >= 7'd1) && (val <= 7'd12);
                month_d = val[3:0];
              end
              PH_DAY: begin
                ok = (val >= 7'd1) && (val <= {2'b00, day_lim});
                day_d = val[4:0];
              end
              PH_HOUR: begin
                ok = (val <= 7'd23);
                hour_d  = val[4:0];
                given_d = 2'd1;
              end
              PH_MINUTE: begin
                ok = (val <= 7'd59);
                minute_d = val[5:0];
                given_d  = 2'd2;
              end
              default: begin
                ok = (val <= 7'd59);
                second_d = val[5:0];
                given_d  = 2'd3;
              end
            endcase
            if (ok) begin
              phase_d   = next_phase(cur_ph);
              has_dig_d = 1'b0;
              skip_d    = 1'b0;
              first_d   = 4'd0;
            end else begin
              // keep stored fields as they were; bad string reports zeros anyway
              month_d   = month_q;
              day_d     = day_q;
              hour_d    = hour_q;
              minute_d  = minute_q;
              second_d  = second_q;
              given_d   = given_q;
              phase_d   = PH_BAD;
              bad_fld_d = fld_idx(cur_ph);
            end
          end
        end
      end
    end
  end

  // Result for an end request, from the current state.
  always_comb begin
    logic       good;
    logic [2:0] bf;
    good = 1'b0;
    bf   = bad_fld_q;
    case (phase_q)
      PH_BLANK: bf = FldYear;
      PH_CENTURY, PH_YEAR, PH_MONTH, PH_DAY: bf = fld_idx(phase_q);
      PH_HOUR, PH_MINUTE, PH_SECOND: begin
        if (has_dig_q || skip_q) begin
          bf = fld_idx(phase_q);
        end else begin
          good = 1'b1;
        end
      end
      PH_DONE: good = 1'b1;
      default: bf = bad_fld_q;
    endcase

    res_o = '0;
    if (good) begin
      res_o.valid_res         = 1'b1;
      res_o.year              = 14'(century_q) * 14'd100 + 14'(year_lo_q);
      res_o.month             = month_q;
      res_o.day               = day_q;
      res_o.hour              = hour_q;
      res_o.minute            = minute_q;
      res_o.second            = second_q;
      res_o.time_fields_given = given_q;
      res_o.leap_year         = leap_now;
    end else begin
      res_o.failed_field = bf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_BLANK;
      first_q   <= 4'd0;
      has_dig_q <= 1'b0;
      skip_q    <= 1'b0;
      century_q <= 7'd0;
      year_lo_q <= 7'd0;
      month_q   <= 4'd0;
      day_q     <= 5'd0;
      hour_q    <= 5'd0;
      minute_q  <= 6'd0;
      second_q  <= 6'd0;
      given_q   <= 2'd0;
      bad_fld_q <= 3'd0;
    end else begin
      phase_q   <= phase_d;
      first_q   <= first_d;
      has_dig_q <= has_dig_d;
      skip_q    <= skip_d;
      century_q <= century_d;
      year_lo_q <= year_lo_d;
      month_q   <= month_d;
      day_q     <= day_d;
      hour_q    <= hour_d;
      minute_q  <= minute_d;
      second_q  <= second_d;
      given_q   <= given_d;
      bad_fld_q <= bad_fld_d;
    end
  end

  ap_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |-> (!has_dig_q && given_q == 2'd3))
    else $error("done phase with pending digit or missing time fields");

  ap_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && is_end_i) |=> (phase_q == PH_BLANK && !has_dig_q && !skip_q))
    else $error("end request did not clear the parser");

  ap_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DAY) |-> (month_q >= 4'd1 && month_q <= 4'd12))
    else $error("day field reached without a valid month");

endmodule

`default_nettype wire

// ----- src/numeric_date_time_parser_top.sv -----
// Top level of the numeric date-time parser: config register, parser core, result register.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one character per request in ch_i;
//   is_end_i marks the end of a string and ch_i is then ignored. Plain characters
//   update the parser state and give no result. An end request gives exactly one
//   result on the output channel (out_valid_o / out_stall_i) and clears the parser.
//   cfg_we_i writes default_century from cfg_wdata_i; write only while idle.
//   Throughput: one request per cycle while in_stall_o is low. Latency: the result of an end request is
//   presented the cycle after it is accepted, from a single result register.
//   Each character passes through one level of next-state logic into the parser
//   state registers.
//   When the receiver stalls with a result held, in_stall_o is raised and no
//   request is taken until the result drains; the held result does not change.
//   Reset clears the parser, empties the result register and sets
//   default_century to 19.
`timescale 1ns / 1ps
`default_nettype none

module numeric_date_time_parser_top import ndtp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        is_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             valid_res_o,
  output logic [2:0]       failed_field_o,
  output logic [13:0]      year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_o,
  output logic [4:0]       hour_o,
  output logic [5:0]       minute_o,
  output logic [5:0]       second_o,
  output logic [1:0]       time_fields_given_o,
  output logic             leap_year_o
);

  logic [6:0] def_cen_q;
  logic       out_vld_q, out_vld_d;
  ndtp_res_t  res_q;
  ndtp_res_t  core_res;
  logic       in_acc;
  logic       end_acc;

  assign in_stall_o = out_vld_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign end_acc    = in_acc && is_end_i;

  ndtp_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (in_acc),
    .ch_i              (ch_i),
    .is_end_i          (is_end_i),
    .default_century_i (def_cen_q),
    .res_o             (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_cen_q <= DefCenturyReset;
    end else if (cfg_we_i) begin
      def_cen_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q && out_stall_i;
    if (end_acc) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_acc) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign valid_res_o         = res_q.valid_res;
  assign failed_field_o      = res_q.failed_field;
  assign year_o              = res_q.year;
  assign month_o             = res_q.month;
  assign day_o               = res_q.day;
  assign hour_o              = res_q.hour;
  assign minute_o            = res_q.minute;
  assign second_o            = res_q.second;
  assign time_fields_given_o = res_q.time_fields_given;
  assign leap_year_o         = res_q.leap_year;

  ap_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_acc |=> out_vld_q)
    else $error("accepted end request produced no result");

  ap_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_vld_q)
    else $error("input stalled with empty result register");

  ap_valid_no_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.valid_res) |-> (res_q.failed_field == FldCentury &&
      res_q.month >= 4'd1 && res_q.month <= 4'd12))
    else $error("valid result with failed field or bad month");

  ap_bad_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_q.valid_res) |-> (res_q.year == 14'd0 &&
      res_q.time_fields_given == 2'd0 && !res_q.leap_year))
    else $error("bad result carries nonzero fields");

endmodule

`default_nettype wire

// ----- dv/numeric_date_time_parser_tb.sv -----
// Testbench for the numeric date-time parser: directed and random strings against a predictor.
`timescale 1ns / 1ps

module testbench import ndtp_pkg::*;;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 400;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [6:0]  cfg_wdata_i = 7'd0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  ch_i        = 8'h00;
  logic        is_end_i    = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        valid_res_o;
  logic [2:0]  failed_field_o;
  logic [13:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;
  logic [1:0]  time_fields_given_o;
  logic        leap_year_o;

  numeric_date_time_parser_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .ch_i               (ch_i),
    .is_end_i           (is_end_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .valid_res_o        (valid_res_o),
    .failed_field_o     (failed_field_o),
    .year_o             (year_o),
    .month_o            (month_o),
    .day_o              (day_o),
    .hour_o             (hour_o),
    .minute_o           (minute_o),
    .second_o           (second_o),
    .time_fields_given_o(time_fields_given_o),
    .leap_year_o        (leap_year_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Parser shadow state
  logic [6:0] century_reg;
  logic       at_blanks, fields_done, str_bad;
  logic [2:0] cur_fld, bad_fld;
  logic [3:0] tens;
  logic       have_tens, sep_seen;
  logic [6:0] cen_v, yr_v;
  logic [3:0] mon_v;
  logic [4:0] day_v, hr_v;
  logic [5:0] min_v, sec_v;
  logic [1:0] n_time;

  ndtp_res_t   exp_dates[$];
  ndtp_res_t   next_date;
  logic [7:0]  line_buf[$];
  int          errors     = 0;
  int unsigned sent_count = 0;
  int unsigned cycles     = 0;
  bit          idle_en    = 1'b1;

  function automatic logic leap_of(int unsigned y);
    return (y % 4 == 0) && ((y % 400 == 0) || (y % 100 != 0));
  endfunction

  function automatic void clear_parse();
    at_blanks = 1'b1; fields_done = 1'b0; str_bad = 1'b0;
    cur_fld = FldCentury; bad_fld = FldCentury;
    tens = 4'd0; have_tens = 1'b0; sep_seen = 1'b0;
    cen_v = 7'd0; yr_v = 7'd0; mon_v = 4'd0; day_v = 5'd0;
    hr_v = 5'd0; min_v = 6'd0; sec_v = 6'd0; n_time = 2'd0;
  endfunction

  function automatic void flag_bad(logic [2:0] f);
    str_bad = 1'b1;
    bad_fld = f;
  endfunction

  function automatic void field_byte(logic [7:0] c);
    logic        dig;
    logic        ok;
    int unsigned v;
    int unsigned lim;
    int unsigned full;
    dig = (c >= ChZero) && (c <= ChNine);
    if (!have_tens) begin
      if (dig) begin
        tens = 4'(c - ChZero);
        have_tens = 1'b1;
      end else begin
        sep_seen = 1'b1;
      end
    end else if (!dig) begin
      flag_bad(cur_fld);
    end else begin
      v = tens * 10 + (c - ChZero);
      ok = 1'b1;
      case (cur_fld)
        FldCentury: cen_v = 7'(v);
        FldYear:    yr_v = 7'(v);
        FldMonth: begin
          if (v >= 1 && v <= 12) mon_v = 4'(v); else ok = 1'b0;
        end
        FldDay: begin
          full = cen_v * 100 + yr_v;
          case (mon_v)
            4'd2:                    lim = leap_of(full) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11: lim = 30;
            default:                 lim = 31;
          endcase
          if (v >= 1 && v <= lim) day_v = 5'(v); else ok = 1'b0;
        end
        FldHour: begin
          if (v <= 23) begin hr_v = 5'(v); n_time = 2'd1; end else ok = 1'b0;
        end
        FldMinute: begin
          if (v <= 59) begin min_v = 6'(v); n_time = 2'd2; end else ok = 1'b0;
        end
        default: begin
          if (v <= 59) begin sec_v = 6'(v); n_time = 2'd3; end else ok = 1'b0;
        end
      endcase
      if (!ok) begin
        flag_bad(cur_fld);
      end else begin
        if (cur_fld == FldSecond) fields_done = 1'b1;
        else cur_fld = cur_fld + 3'd1;
        tens = 4'd0; have_tens = 1'b0; sep_seen = 1'b0;
      end
    end
  endfunction

  function automatic void parse_char(logic [7:0] c, logic e);
    ndtp_res_t   r;
    int unsigned full;
    if (e) begin
      r = '0;
      if (at_blanks) flag_bad(FldYear);
      else if (!fields_done && !str_bad &&
               (cur_fld <= FldDay || have_tens || sep_seen)) flag_bad(cur_fld);
      if (str_bad) begin
        r.failed_field = bad_fld;
      end else begin
        full = cen_v * 100 + yr_v;
        r.valid_res         = 1'b1;
        r.year              = 14'(full);
        r.month             = mon_v;
        r.day               = day_v;
        r.hour              = hr_v;
        r.minute            = min_v;
        r.second            = sec_v;
        r.time_fields_given = n_time;
        r.leap_year         = leap_of(full);
      end
      exp_dates.push_back(r);
      clear_parse();
    end else if (at_blanks) begin
      if (c == ChPlus) begin
        at_blanks = 1'b0;
        cur_fld = FldCentury;
      end else if (c != ChSpace) begin
        at_blanks = 1'b0;
        cen_v = (century_reg > MaxCentury) ? MaxCentury : century_reg;
        cur_fld = FldYear;
        field_byte(c);
      end
    end else if (!fields_done && !str_bad) begin
      field_byte(c);
    end
  endfunction

  function automatic void check_field(string name, logic [13:0] want, logic [13:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_dates.size() == 0) begin
        $error("result arrived with none expected");
        errors++;
      end else begin
        next_date = exp_dates.pop_front();
        check_field("valid_res", next_date.valid_res, valid_res_o);
        check_field("failed_field", next_date.failed_field, failed_field_o);
        check_field("year", next_date.year, year_o);
        check_field("month", next_date.month, month_o);
        check_field("day", next_date.day, day_o);
        check_field("hour", next_date.hour, hour_o);
        check_field("minute", next_date.minute, minute_o);
        check_field("second", next_date.second, second_o);
        check_field("time_fields_given", next_date.time_fields_given, time_fields_given_o);
        check_field("leap_year", next_date.leap_year, leap_year_o);
      end
    end
  end

  // Receiver stall bursts
  always begin
    @(posedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic e);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    is_end_i   <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_char(c, e);
    sent_count++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i], 1'b0);
    send_char(8'($urandom), 1'b1);
    line_buf.delete();
  endtask

  function automatic void load_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void push_pair(int unsigned v);
    line_buf.push_back(ChZero + 8'(v / 10));
    line_buf.push_back(ChZero + 8'(v % 10));
  endfunction

  function automatic void push_sep();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c >= ChZero && c <= ChNine);
    line_buf.push_back(c);
  endfunction

  function automatic void maybe_sep();
    if ($urandom_range(0, 9) < 3) repeat ($urandom_range(1, 2)) push_sep();
  endfunction

  // Well-formed date text with random content, mostly in range
  function automatic void build_date_text();
    int unsigned m, d, nt;
    repeat ($urandom_range(0, 2)) line_buf.push_back(ChSpace);
    if ($urandom_range(0, 2) == 0) begin
      line_buf.push_back(ChPlus);
      case ($urandom_range(0, 3))
        0:       push_pair(0);
        1:       push_pair(19);
        2:       push_pair(20);
        default: push_pair($urandom_range(0, 99));
      endcase
    end
    push_pair(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 99));
    case ($urandom_range(0, 9))
      0:       m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
      1, 2:    m = 2;
      default: m = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 7))
      0:       d = $urandom_range(28, 31);
      1:       d = $urandom_range(0, 1) ? 0 : $urandom_range(32, 99);
      2:       d = $urandom_range(29, 30);
      default: d = $urandom_range(1, 28);
    endcase
    maybe_sep();
    push_pair(m);
    maybe_sep();
    push_pair(d);
    nt = $urandom_range(0, 3);
    for (int i = 0; i < nt; i++) begin
      maybe_sep();
      if ($urandom_range(0, 9) == 0) push_pair($urandom_range((i == 0) ? 24 : 60, 99));
      else push_pair($urandom_range(0, (i == 0) ? 23 : 59));
    end
    if (nt == 3 && $urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom));
    end
  endfunction

  task automatic set_century(input logic [6:0] v);
    wait_results_in();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    century_reg = v;
  endtask

  task automatic wait_results_in();
    in_valid_i <= 1'b0;
    while (exp_dates.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic test_directed_dates();
    load_text("991231235959"); send_line();
    load_text("+00000229");    send_line();
    load_text("+20000229");    send_line();
    load_text("000229");       send_line();
    send_line();
    load_text("  ");           send_line();
    load_text("+");            send_line();
    load_text("9");            send_line();
    load_text("9-");           send_line();
    load_text("990101 ");      send_line();
    load_text("990101"); line_buf.push_back(8'h00); load_text("12"); send_line();
    load_text("991301");       send_line();
    load_text("990431");       send_line();
    load_text("99010124");     send_line();
    load_text("9901012360");   send_line();
    load_text("99010123596");  send_line();
    load_text("991231235959abc"); send_line();
  endtask

  task automatic test_century_register();
    logic [6:0] vals[5];
    vals = '{7'd0, 7'd99, 7'd100, 7'd127, 7'($urandom_range(0, 127))};
    foreach (vals[i]) begin
      set_century(vals[i]);
      load_text("000229");     send_line();
      load_text(" 9912311");   send_line();
    end
    set_century(DefCenturyReset);
  endtask

  task automatic test_pause_until_drained();
    repeat (4) begin
      build_date_text();
      send_line();
      wait_results_in();
    end
  endtask

  task automatic test_random_strings();
    int unsigned stop_at, next_cfg, kind, cut;
    stop_at  = sent_count + RandomItems;
    next_cfg = sent_count + 100;
    while (sent_count < stop_at) begin
      if (sent_count >= next_cfg) begin
        case ($urandom_range(0, 5))
          0:       set_century(7'd0);
          1:       set_century(7'd19);
          2:       set_century(7'd20);
          3:       set_century(7'd99);
          4:       set_century(7'($urandom_range(100, 127)));
          default: set_century(7'($urandom_range(0, 127)));
        endcase
        idle_en  = ($urandom_range(0, 3) != 0);
        next_cfg = sent_count + 100;
      end
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat ($urandom_range(0, 20)) begin
          if ($urandom_range(0, 1)) line_buf.push_back(ChZero + 8'($urandom_range(0, 9)));
          else line_buf.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        build_date_text();
        if (kind < 25) begin
          // truncated string, sometimes with a trailing separator
          cut = $urandom_range(0, line_buf.size() - 1);
          while (line_buf.size() > cut) void'(line_buf.pop_back());
          if ($urandom_range(0, 1)) push_sep();
        end
      end
      send_line();
    end
    idle_en = 1'b1;
  endtask

  task automatic test_without_idling();
    idle_en = 1'b0;
    repeat (10) begin
      build_date_text();
      send_line();
    end
  endtask

  initial begin
    century_reg = DefCenturyReset;
    clear_parse();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_dates();
    test_century_register();
    test_pause_until_drained();
    test_random_strings();
    test_without_idling();
    wait_results_in();
    repeat (4) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
